@@ design/stereo_disparity_reprojection_core_defines.svh @@
// assertion macros for the stereo disparity reprojection core
// no dependencies
`ifndef STEREO_DISPARITY_REPROJECTION_CORE_DEFINES_SVH
`define STEREO_DISPARITY_REPROJECTION_CORE_DEFINES_SVH
`ifndef SYNTH
`define SDR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SDR_ASSERT_NEXT(lbl, clk, rstn, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);
`else
`define SDR_ASSERT(lbl, clk, rstn, prop, msg)
`define SDR_ASSERT_NEXT(lbl, clk, rstn, a, b, msg)
`endif
`endif

@@ design/sdr_pkg.sv @@
// shared types and constants for the stereo disparity reprojection core
// no dependencies
package sdr_pkg;
  localparam int unsigned DispW  = 16;
  localparam int unsigned PixW   = 12;
  localparam int unsigned CfgW   = 24;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned QuotW  = 32;

  typedef enum logic [IdxW-1:0] {
    RegFocal   = 3'd0,
    RegCol     = 3'd1,
    RegRow     = 3'd2,
    RegWidth   = 3'd3,
    RegHeight  = 3'd4,
    RegBase    = 3'd5,
    RegDepLow  = 3'd6,
    RegDepHigh = 3'd7
  } reg_idx_e;

  // classified item handed from front to back
  typedef struct packed {
    logic        ok;
    logic [31:0] num_z;
    logic        neg_x;
    logic [31:0] num_x;
    logic        neg_y;
    logic [31:0] num_y;
    logic [DispW-1:0] disp;
  } front_item_t;
endpackage

@@ design/sdr_front.sv @@
// front part: checks the pixel and forms the numerators
// depends on sdr_pkg
module sdr_front (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic [sdr_pkg::PixW-1:0] pixel_col_i,
  input  logic [sdr_pkg::PixW-1:0] pixel_row_i,
  input  logic [sdr_pkg::DispW-1:0] disparity_val_i,
  input  logic [15:0] focal_i,
  input  logic [15:0] ccol_i,
  input  logic [15:0] crow_i,
  input  logic [12:0] width_i,
  input  logic [12:0] height_i,
  input  logic [15:0] base_i,
  output logic out_valid_o,
  output sdr_pkg::front_item_t item_o
);
  logic [16:0] pc, pr;
  logic [16:0] mc, mr;
  logic neg_c, neg_r;
  logic ok;
  logic valid_q;
  sdr_pkg::front_item_t item_q;

  always_comb begin
    pc = {1'b0, pixel_col_i, 4'b0};
    pr = {1'b0, pixel_row_i, 4'b0};
    neg_c = {1'b0, ccol_i} > pc;
    neg_r = {1'b0, crow_i} > pr;
    mc = neg_c ? ({1'b0, ccol_i} - pc) : (pc - {1'b0, ccol_i});
    mr = neg_r ? ({1'b0, crow_i} - pr) : (pr - {1'b0, crow_i});
    ok = (disparity_val_i != '0) && (base_i != '0) && (focal_i != '0) &&
         ({1'b0, pixel_col_i} < width_i) && ({1'b0, pixel_row_i} < height_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q.ok    <= ok;
    item_q.num_z <= 32'(focal_i) * 32'(base_i);
    item_q.neg_x <= neg_c;
    item_q.num_x <= 32'(mc) * 32'(base_i);
    item_q.neg_y <= neg_r;
    item_q.num_y <= 32'(mr) * 32'(base_i);
    item_q.disp  <= disparity_val_i;
  end

  assign out_valid_o = valid_q;
  assign item_o = item_q;
endmodule

@@ design/sdr_divider.sv @@
// pipelined restoring divider, one quotient bit per stage
// depends on nothing
module sdr_divider #(
  parameter int unsigned NumW = 37,
  parameter int unsigned DenW = 26,
  parameter int unsigned TagW = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [TagW-1:0] tag_i,
  output logic out_valid_o,
  output logic [NumW-1:0] quot_o,
  output logic [TagW-1:0] tag_o
);
  logic            vld_q [NumW+1];
  logic [NumW-1:0] num_q [NumW+1];
  logic [DenW:0]   rem_q [NumW+1];
  logic [DenW-1:0] den_q [NumW+1];
  logic [TagW-1:0] tag_q [NumW+1];

  always_comb begin
    vld_q[0] = in_valid_i;
    num_q[0] = num_i;
    rem_q[0] = '0;
    den_q[0] = den_i;
    tag_q[0] = tag_i;
  end

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [DenW+1:0] tr;
    logic [DenW+1:0] df;
    always_comb begin
      tr = {rem_q[s], num_q[s][NumW-1]};
      df = tr - {2'b0, den_q[s]};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (!df[DenW+1]) begin
        rem_q[s+1] <= df[DenW:0];
        num_q[s+1] <= {num_q[s][NumW-2:0], 1'b1};
      end else begin
        rem_q[s+1] <= tr[DenW:0];
        num_q[s+1] <= {num_q[s][NumW-2:0], 1'b0};
      end
      den_q[s+1] <= den_q[s];
      tag_q[s+1] <= tag_q[s];
    end
  end

  assign out_valid_o = vld_q[NumW];
  assign quot_o = num_q[NumW];
  assign tag_o = tag_q[NumW];
endmodule

@@ design/sdr_back.sv @@
// back part: three dividers, range test, saturation and result register
// depends on sdr_pkg and sdr_divider
`include "stereo_disparity_reprojection_core_defines.svh"
module sdr_back #(
  parameter int unsigned DispFracBits = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sdr_pkg::front_item_t item_i,
  input  logic [23:0] dlow_i,
  input  logic [23:0] dhigh_i,
  output logic done_o,
  output logic point_valid_o,
  output logic [31:0] point_x_o,
  output logic [31:0] point_y_o,
  output logic [23:0] point_z_o
);
  localparam int unsigned NumW = 32 + DispFracBits;
  localparam int unsigned DenW = sdr_pkg::DispW + 10;

  logic [NumW-1:0] qz, qx, qy;
  logic ok_z, neg_x, neg_y;
  logic vz, vx, vy;
  logic [DenW-1:0] den;
  logic acc;
  logic [NumW-1:0] sx, sy;
  logic done_q, pv_q;
  logic [31:0] x_q, y_q;
  logic [23:0] z_q;

  assign den = {item_i.disp, 10'b0};

  sdr_divider #(.NumW(NumW), .DenW(DenW), .TagW(1)) u_div_z (
    .clk_i, .rst_ni, .in_valid_i,
    .num_i({item_i.num_z, {DispFracBits{1'b0}}}), .den_i(den),
    .tag_i(item_i.ok),
    .out_valid_o(vz), .quot_o(qz), .tag_o(ok_z));
  sdr_divider #(.NumW(NumW), .DenW(DenW), .TagW(1)) u_div_x (
    .clk_i, .rst_ni, .in_valid_i,
    .num_i({item_i.num_x, {DispFracBits{1'b0}}}), .den_i(den), .tag_i(item_i.neg_x),
    .out_valid_o(vx), .quot_o(qx), .tag_o(neg_x));
  sdr_divider #(.NumW(NumW), .DenW(DenW), .TagW(1)) u_div_y (
    .clk_i, .rst_ni, .in_valid_i,
    .num_i({item_i.num_y, {DispFracBits{1'b0}}}), .den_i(den), .tag_i(item_i.neg_y),
    .out_valid_o(vy), .quot_o(qy), .tag_o(neg_y));

  function automatic logic [31:0] sat(input logic [NumW-1:0] q, input logic neg);
    logic [31:0] r;
    if (neg) begin
      r = (q > NumW'(33'h80000000)) ? 32'h80000000 : (32'd0 - q[31:0]);
    end else begin
      r = (q > NumW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : q[31:0];
    end
    return r;
  endfunction

  always_comb begin
    acc = vz && ok_z && (qz >= NumW'(dlow_i)) && (qz <= NumW'(dhigh_i));
    sx = qx;
    sy = qy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vz;
    end
  end

  always_ff @(posedge clk_i) begin
    pv_q <= acc;
    x_q  <= acc ? sat(sx, neg_x) : '0;
    y_q  <= acc ? sat(sy, neg_y) : '0;
    z_q  <= acc ? qz[23:0] : '0;
  end

  assign done_o = done_q;
  assign point_valid_o = pv_q;
  assign point_x_o = x_q;
  assign point_y_o = y_q;
  assign point_z_o = z_q;

  `SDR_ASSERT(a_lanes_aligned, clk_i, rst_ni, (vz == vx) && (vz == vy), "lanes out of step")
  `SDR_ASSERT_NEXT(a_invalid_zero, clk_i, rst_ni, vz && !acc, (z_q == '0) && (x_q == '0), "reject not zero")
  `SDR_ASSERT_NEXT(a_done_follows, clk_i, rst_ni, vz, done_o, "result strobe lost")
endmodule

@@ design/stereo_disparity_reprojection_core.sv @@
// top level of the stereo disparity reprojection core
// depends on sdr_pkg, sdr_front, sdr_back, sdr_divider
//
// channel   ports                                            handshake
// config    cfg_we_i cfg_idx_i cfg_wdata_i                   write when cfg_we_i
// pixel     pixel_col_i pixel_row_i disparity_val_i          start && !busy
// point     point_valid_o point_x_o point_y_o point_z_o      done, one cycle
//
// one item per clock; done rises once the item has passed the front, divider and result registers
// stages: front register, 32 + DISP_FRAC_BITS divider stages, result register
// busy is always low: the pipeline never stalls and the receiver cannot stall
// reset clears the valid chain and loads the default calibration
`include "stereo_disparity_reprojection_core_defines.svh"
module stereo_disparity_reprojection_core #(
  parameter int unsigned DISP_FRAC_BITS = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  logic cfg_we_i,
  input  logic [sdr_pkg::IdxW-1:0] cfg_idx_i,
  input  logic [sdr_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic [sdr_pkg::PixW-1:0] pixel_col_i,
  input  logic [sdr_pkg::PixW-1:0] pixel_row_i,
  input  logic [sdr_pkg::DispW-1:0] disparity_val_i,
  output logic done,
  output logic point_valid_o,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic [23:0] point_z_o
);
  // calibration registers
  logic [15:0] focal_q, ccol_q, crow_q, base_q;
  logic [12:0] width_q, height_q;
  logic [23:0] dlow_q, dhigh_q;

  logic fv;
  sdr_pkg::front_item_t fitem;
  logic [31:0] px, py;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q  <= 16'd8000;
      ccol_q   <= 16'd5120;
      crow_q   <= 16'd3840;
      width_q  <= 13'd640;
      height_q <= 13'd480;
      base_q   <= 16'd3277;
      dlow_q   <= 24'd205;
      dhigh_q  <= 24'd5120;
    end else if (cfg_we_i) begin
      unique case (sdr_pkg::reg_idx_e'(cfg_idx_i))
        sdr_pkg::RegFocal:   focal_q  <= cfg_wdata_i[15:0];
        sdr_pkg::RegCol:     ccol_q   <= cfg_wdata_i[15:0];
        sdr_pkg::RegRow:     crow_q   <= cfg_wdata_i[15:0];
        sdr_pkg::RegWidth:   width_q  <= cfg_wdata_i[12:0];
        sdr_pkg::RegHeight:  height_q <= cfg_wdata_i[12:0];
        sdr_pkg::RegBase:    base_q   <= cfg_wdata_i[15:0];
        sdr_pkg::RegDepLow:  dlow_q   <= cfg_wdata_i;
        sdr_pkg::RegDepHigh: dhigh_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // fully pipelined, so the core never pushes back
  assign busy = 1'b0;

  sdr_front u_front (
    .clk_i, .rst_ni, .in_valid_i(start && !busy),
    .pixel_col_i, .pixel_row_i, .disparity_val_i,
    .focal_i(focal_q), .ccol_i(ccol_q), .crow_i(crow_q),
    .width_i(width_q), .height_i(height_q), .base_i(base_q),
    .out_valid_o(fv), .item_o(fitem));

  sdr_back #(.DispFracBits(DISP_FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .in_valid_i(fv), .item_i(fitem),
    .dlow_i(dlow_q), .dhigh_i(dhigh_q),
    .done_o(done), .point_valid_o, .point_x_o(px), .point_y_o(py),
    .point_z_o);

  assign point_x_o = px;
  assign point_y_o = py;

  `SDR_ASSERT(a_never_busy, clk_i, rst_ni, !busy, "core pushed back")
  `SDR_ASSERT(a_valid_strobed, clk_i, rst_ni, point_valid_o |-> done, "valid point outside strobe")
  `SDR_ASSERT(a_z_range, clk_i, rst_ni, point_valid_o |-> (point_z_o != '0 || dlow_q == '0), "zero depth")
endmodule
